// File: rtl/core/process_table_round_robin_scheduler_unit_assert.svh
// Assertion macros used by the scheduler control module.
`ifndef PROCESS_TABLE_ROUND_ROBIN_SCHEDULER_UNIT_ASSERT_SVH
`define PROCESS_TABLE_ROUND_ROBIN_SCHEDULER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTRR_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTRR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("scheduler assertion failed");

`endif

// File: rtl/core/ptrr_pkg.sv
package ptrr_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int PID_BITS   = 16;
  localparam int SLOT_BITS  = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;

  localparam int MODE_W = 2;
  localparam int TPID_W = 16;
  localparam int CODE_W = 32;
  localparam int STAT_W = 2;
  localparam int RPID_W = 16;
  localparam int CSLT_W = 4;

  typedef enum logic [2:0] {
    ST_EMPTY   = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_ZOMBIE  = 3'd4
  } slot_state_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SPAWN = 2'd0,
    MODE_EXIT  = 2'd1,
    MODE_WAIT  = 2'd2,
    MODE_YIELD = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_NOPROC  = 2'd2,
    STATUS_BLOCKED = 2'd3
  } status_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] idx;
    logic                 load_in;
    logic                 latch_cur;
    logic                 latch_blk;
    logic                 wr_state;
    slot_state_t          state_val;
    logic                 spawn_wr;
    logic                 exit_wr;
    logic                 reap;
    logic                 set_run;
    logic                 set_status;
    status_t              status_val;
    logic                 load_out;
  } cmd_t;

  typedef struct packed {
    slot_state_t          st;
    logic                 pid_hit;
    logic                 child_hit;
    logic                 parent_hit;
    mode_t                mode;
    logic [SLOT_BITS-1:0] running;
    logic [SLOT_BITS-1:0] prev;
  } stat_t;

endpackage

// File: rtl/core/ptrr_req_if.sv
interface ptrr_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptrr_pkg::MODE_W-1:0]   mode;
  logic [ptrr_pkg::TPID_W-1:0]   target_pid;
  logic signed [ptrr_pkg::CODE_W-1:0] exit_value;

  modport source (output valid, mode, target_pid, exit_value, input ready);
  modport sink (input valid, mode, target_pid, exit_value, output ready);
endinterface

// File: rtl/core/ptrr_rsp_if.sv
interface ptrr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ptrr_pkg::STAT_W-1:0]   status;
  logic [ptrr_pkg::RPID_W-1:0]   result_pid;
  logic signed [ptrr_pkg::CODE_W-1:0] exit_value_out;
  logic [ptrr_pkg::CSLT_W-1:0]   current_slot;
  logic                          switched;

  modport source (output valid, status, result_pid, exit_value_out, current_slot, switched,
                  input ready);
  modport sink (input valid, status, result_pid, exit_value_out, current_slot, switched,
                output ready);
endinterface

// File: rtl/core/ptrr_datapath.sv
module ptrr_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  ptrr_pkg::cmd_t                     cmd,
  output ptrr_pkg::stat_t                    stat,
  input  logic [ptrr_pkg::MODE_W-1:0]        mode,
  input  logic [ptrr_pkg::TPID_W-1:0]        target_pid,
  input  logic signed [ptrr_pkg::CODE_W-1:0] exit_value,
  output logic [ptrr_pkg::STAT_W-1:0]        status,
  output logic [ptrr_pkg::RPID_W-1:0]        result_pid,
  output logic signed [ptrr_pkg::CODE_W-1:0] exit_value_out,
  output logic [ptrr_pkg::CSLT_W-1:0]        current_slot,
  output logic                               switched
);
  localparam int N  = ptrr_pkg::SLOT_COUNT;
  localparam int SB = ptrr_pkg::SLOT_BITS;
  localparam int PB = ptrr_pkg::PID_BITS;
  localparam int CW = PB + ptrr_pkg::TPID_W;
  localparam int RW = PB + ptrr_pkg::RPID_W;
  localparam int SW = SB + ptrr_pkg::CSLT_W;

  ptrr_pkg::slot_state_t              slot_st   [N];
  logic [PB-1:0]                      slot_pid  [N];
  logic [PB-1:0]                      slot_par  [N];
  logic [ptrr_pkg::CODE_W-1:0]        slot_code [N];
  logic [SB-1:0]                      running;
  logic [SB-1:0]                      prev;
  logic [PB-1:0]                      pid_counter;
  ptrr_pkg::mode_t                    mode_r;
  logic [ptrr_pkg::TPID_W-1:0]        target_r;
  logic [ptrr_pkg::CODE_W-1:0]        code_r;
  logic [PB-1:0]                      cur_pid;
  logic [PB-1:0]                      blk_pid;
  ptrr_pkg::status_t                  res_status;
  logic [ptrr_pkg::RPID_W-1:0]        res_pid;
  logic [ptrr_pkg::CODE_W-1:0]        res_code;
  logic                               res_sw;
  logic [CW-1:0]                      pid_x;
  logic [CW-1:0]                      tgt_x;
  logic [RW-1:0]                      cnt_x;
  logic [SW-1:0]                      run_x;

  assign pid_x = CW'(slot_pid[cmd.idx]);
  assign tgt_x = CW'(target_r);
  assign cnt_x = RW'(pid_counter);
  assign run_x = SW'(running);

  always_comb begin
    stat.st         = slot_st[cmd.idx];
    stat.pid_hit    = (pid_x == tgt_x);
    stat.child_hit  = (slot_pid[cmd.idx] == cur_pid);
    stat.parent_hit = (slot_par[cmd.idx] == blk_pid);
    stat.mode       = mode_r;
    stat.running    = running;
    stat.prev       = prev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < N; n++) begin
        slot_st[n]   <= (n == 0) ? ptrr_pkg::ST_READY : ptrr_pkg::ST_EMPTY;
        slot_pid[n]  <= '0;
        slot_par[n]  <= '0;
        slot_code[n] <= '0;
      end
      running     <= '0;
      prev        <= '0;
      pid_counter <= PB'(1);
    end else begin
      if (cmd.wr_state) begin
        slot_st[cmd.idx] <= cmd.state_val;
      end
      if (cmd.spawn_wr) begin
        slot_pid[cmd.idx]  <= pid_counter;
        slot_par[cmd.idx]  <= cur_pid;
        slot_code[cmd.idx] <= '0;
        pid_counter        <= pid_counter + PB'(1);
      end
      if (cmd.exit_wr) begin
        slot_code[cmd.idx] <= code_r;
      end
      if (cmd.set_run) begin
        prev    <= running;
        running <= cmd.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_r     <= ptrr_pkg::mode_t'(mode);
      target_r   <= target_pid;
      code_r     <= exit_value;
      res_status <= ptrr_pkg::STATUS_OK;
      res_pid    <= '0;
      res_code   <= '0;
      res_sw     <= 1'b0;
    end
    if (cmd.latch_cur) begin
      cur_pid <= slot_pid[cmd.idx];
    end
    if (cmd.latch_blk) begin
      blk_pid <= slot_pid[cmd.idx];
    end
    if (cmd.spawn_wr) begin
      res_pid <= cnt_x[ptrr_pkg::RPID_W-1:0];
    end
    if (cmd.reap) begin
      res_code <= slot_code[cmd.idx];
      res_pid  <= target_r;
    end
    if (cmd.set_run) begin
      res_sw <= 1'b1;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_val;
    end
    if (cmd.load_out) begin
      status         <= res_status;
      result_pid     <= res_pid;
      exit_value_out <= res_code;
      current_slot   <= run_x[ptrr_pkg::CSLT_W-1:0];
      switched       <= res_sw;
    end
  end
endmodule

// File: rtl/core/ptrr_ctrl.sv
`include "process_table_round_robin_scheduler_unit_assert.svh"
module ptrr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  ptrr_pkg::stat_t stat,
  output ptrr_pkg::cmd_t  cmd
);
  localparam int N  = ptrr_pkg::SLOT_COUNT;
  localparam int SB = ptrr_pkg::SLOT_BITS;
  localparam logic [SB-1:0] LAST = SB'(N - 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CUR   = 11'b00000000010,
    S_SPAWN = 11'b00000000100,
    S_WI    = 11'b00000001000,
    S_WJ    = 11'b00000010000,
    S_WAKE  = 11'b00000100000,
    S_WAITS = 11'b00001000000,
    S_BLOCK = 11'b00010000000,
    S_RS    = 11'b00100000000,
    S_FIX   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } fsm_t;

  fsm_t          state, state_next;
  logic [SB-1:0] i, i_next, j, j_next, k, k_next;
  logic [SB:0]   rs_sum;
  logic [SB-1:0] rs_idx;
  logic          out_free;

  assign rs_sum   = {1'b0, stat.running} + {1'b0, k};
  assign rs_idx   = (rs_sum >= (SB+1)'(N)) ? SB'(rs_sum - (SB+1)'(N)) : rs_sum[SB-1:0];
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    cmd        = '0;
    cmd.state_val  = ptrr_pkg::ST_EMPTY;
    cmd.status_val = ptrr_pkg::STATUS_OK;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CUR;
        end
      end
      S_CUR: begin
        cmd.idx       = stat.running;
        cmd.latch_cur = 1'b1;
        i_next        = '0;
        k_next        = SB'(1);
        case (stat.mode)
          ptrr_pkg::MODE_SPAWN: state_next = S_SPAWN;
          ptrr_pkg::MODE_EXIT: begin
            if (stat.st == ptrr_pkg::ST_EMPTY || stat.st == ptrr_pkg::ST_ZOMBIE) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ptrr_pkg::STATUS_NOPROC;
              state_next     = S_DONE;
            end else begin
              cmd.wr_state  = 1'b1;
              cmd.state_val = ptrr_pkg::ST_ZOMBIE;
              cmd.exit_wr   = 1'b1;
              state_next    = S_WI;
            end
          end
          ptrr_pkg::MODE_WAIT: state_next = S_WAITS;
          default: state_next = S_RS;
        endcase
      end
      S_SPAWN: begin
        cmd.idx = i;
        if (stat.st == ptrr_pkg::ST_EMPTY) begin
          cmd.spawn_wr  = 1'b1;
          cmd.wr_state  = 1'b1;
          cmd.state_val = ptrr_pkg::ST_READY;
          state_next    = S_DONE;
        end else if (i == LAST) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ptrr_pkg::STATUS_FULL;
          state_next     = S_DONE;
        end else begin
          i_next = i + SB'(1);
        end
      end
      S_WI: begin
        cmd.idx = i;
        if (stat.st == ptrr_pkg::ST_BLOCKED) begin
          cmd.latch_blk = 1'b1;
          j_next        = '0;
          state_next    = S_WJ;
        end else if (i == LAST) begin
          state_next = S_RS;
        end else begin
          i_next = i + SB'(1);
        end
      end
      S_WJ: begin
        cmd.idx = j;
        if (stat.st != ptrr_pkg::ST_EMPTY && stat.child_hit && stat.parent_hit) begin
          state_next = S_WAKE;
        end else if (j == LAST) begin
          if (i == LAST) begin
            state_next = S_RS;
          end else begin
            i_next     = i + SB'(1);
            state_next = S_WI;
          end
        end else begin
          j_next = j + SB'(1);
        end
      end
      S_WAKE: begin
        cmd.idx       = i;
        cmd.wr_state  = 1'b1;
        cmd.state_val = ptrr_pkg::ST_READY;
        state_next    = S_RS;
      end
      S_WAITS: begin
        cmd.idx = i;
        if (stat.st != ptrr_pkg::ST_EMPTY && stat.pid_hit) begin
          if (stat.st == ptrr_pkg::ST_ZOMBIE) begin
            cmd.reap      = 1'b1;
            cmd.wr_state  = 1'b1;
            cmd.state_val = ptrr_pkg::ST_EMPTY;
            state_next    = S_DONE;
          end else begin
            state_next = S_BLOCK;
          end
        end else if (i == LAST) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ptrr_pkg::STATUS_NOPROC;
          state_next     = S_DONE;
        end else begin
          i_next = i + SB'(1);
        end
      end
      S_BLOCK: begin
        cmd.idx        = stat.running;
        cmd.wr_state   = (stat.st == ptrr_pkg::ST_READY || stat.st == ptrr_pkg::ST_RUNNING);
        cmd.state_val  = ptrr_pkg::ST_BLOCKED;
        cmd.set_status = 1'b1;
        cmd.status_val = ptrr_pkg::STATUS_BLOCKED;
        state_next     = S_RS;
      end
      S_RS: begin
        cmd.idx = rs_idx;
        if (stat.st == ptrr_pkg::ST_READY) begin
          cmd.wr_state  = 1'b1;
          cmd.state_val = ptrr_pkg::ST_RUNNING;
          cmd.set_run   = 1'b1;
          state_next    = S_FIX;
        end else if (k == LAST) begin
          state_next = S_DONE;
        end else begin
          k_next = k + SB'(1);
        end
      end
      S_FIX: begin
        cmd.idx       = stat.prev;
        cmd.wr_state  = (stat.st == ptrr_pkg::ST_RUNNING);
        cmd.state_val = ptrr_pkg::ST_READY;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PTRR_ASSERT_NEXT(a_accept_to_cur, in_valid && in_ready, state == S_CUR)
  `PTRR_ASSERT_NEXT(a_done_shows_word, state == S_DONE && out_free, out_valid && state == S_IDLE)
  `PTRR_ASSERT_NOW(a_fix_after_rs, state == S_FIX, $past(state == S_RS))
  `PTRR_ASSERT_NOW(a_rs_skips_self, state == S_RS, k != '0)
endmodule

// File: rtl/core/process_table_round_robin_scheduler_unit.sv
// Operation: one slot is examined a cycle; a spawn scans for an empty slot, a yield scans for
// the next ready slot, a wait scans for the target and may then scan for a ready slot, and an
// exit is the longest, set by the nested parent-wake scan over the slot table.
// Throughput: one event at a time; the next word is taken once the result is registered.
// Reset: synchronous, active high; slot 0 ready, all other slots empty, next id one.
module process_table_round_robin_scheduler_unit (
  input  logic      clk,
  input  logic      rst,
  ptrr_req_if.sink  req,
  ptrr_rsp_if.source rsp
);
  ptrr_pkg::cmd_t  cmd;
  ptrr_pkg::stat_t stat;

  ptrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptrr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (req.mode),
    .target_pid     (req.target_pid),
    .exit_value     (req.exit_value),
    .status         (rsp.status),
    .result_pid     (rsp.result_pid),
    .exit_value_out (rsp.exit_value_out),
    .current_slot   (rsp.current_slot),
    .switched       (rsp.switched)
  );
endmodule
